>>> sv/mwe_pkg.sv
// ============================================================================
// mwe_pkg: shared types and codes for the Microwire EEPROM master
// Transaction payload structs, action codes, serial phase encoding and the
// opcode bytes used to build the command frame.
// ============================================================================
package mwe_pkg;

    // action codes carried by an input transaction
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_WEN   = 3'd3;
    localparam logic [2:0] ACT_WDS   = 3'd4;

    // command bytes; the top five bits form start, opcode and enable field
    localparam logic [7:0] CMD_EWEN  = 8'h98;
    localparam logic [7:0] CMD_EWDS  = 8'h80;
    localparam logic [7:0] CMD_WRITE = 8'hA0;
    localparam logic [7:0] CMD_READ  = 8'hC0;

    localparam int HALF_PERIOD_BITS = 8;
    localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 8'd1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_WDATA = 3'd2,
        PH_RDATA = 3'd3,
        PH_GAP   = 3'd4,
        PH_POLL  = 3'd5
    } mwe_phase_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  address;
        logic [15:0] write_data;
        logic        serial_in;
    } mwe_in_t;

    typedef struct packed {
        logic        chip_select;
        logic        serial_clock;
        logic        serial_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
    } mwe_out_t;

endpackage

>>> sv/mwe_core.sv
// ============================================================================
// mwe_core: serial engine of the Microwire EEPROM master
// Holds the engine state and advances it by one tick per step. The line
// levels of the tick are derived from the updated state.
// ============================================================================
module mwe_core
    import mwe_pkg::*;
#(
    parameter int COMMAND_BITS = 11,
    parameter int ADDRESS_BITS = 8,
    parameter int WORD_BITS    = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  mwe_in_t                     item,
    input  logic [HALF_PERIOD_BITS-1:0] half_period,
    output mwe_out_t                    result
);

    localparam int SHIFT_BITS = (COMMAND_BITS > WORD_BITS) ? COMMAND_BITS : WORD_BITS;
    localparam int BL_W       = $clog2(SHIFT_BITS + 1);
    localparam int IDX_W      = $clog2(SHIFT_BITS);
    localparam int FIELD_A    = (ADDRESS_BITS < 8) ? ADDRESS_BITS : 8;
    localparam int FIELD_BITS = (FIELD_A < COMMAND_BITS - 3) ? FIELD_A : COMMAND_BITS - 3;

    mwe_phase_t                  phase_reg, phase_next;
    logic [SHIFT_BITS-1:0]       out_shift_reg, out_shift_next;
    logic [WORD_BITS-1:0]        in_shift_reg, in_shift_next;
    logic [WORD_BITS-1:0]        write_hold_reg, write_hold_next;
    logic [BL_W-1:0]             bits_left_reg, bits_left_next;
    logic [HALF_PERIOD_BITS-1:0] tick_div_reg, tick_div_next;
    logic                        clock_level_reg, clock_level_next;
    logic [2:0]                  pending_kind_reg, pending_kind_next;
    logic                        done;

    logic [HALF_PERIOD_BITS-1:0] hp;
    logic [COMMAND_BITS-1:0]     frame;
    logic [7:0]                  cmd;

    assign hp = (half_period == '0) ? HALF_PERIOD_BITS'(1) : half_period;

    // command frame: start, opcode, enable field, then the address
    always_comb
    begin
        unique case (item.action)
            ACT_READ:  cmd = CMD_READ;
            ACT_WRITE: cmd = CMD_WRITE;
            ACT_WEN:   cmd = CMD_EWEN;
            default:   cmd = CMD_EWDS;
        endcase
        frame = '0;
        frame[COMMAND_BITS-1 -: 5] = cmd[7:3];
        if (item.action == ACT_READ || item.action == ACT_WRITE)
        begin
            frame[FIELD_BITS-1:0] = frame[FIELD_BITS-1:0] | item.address[FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            out_shift_reg    <= '0;
            in_shift_reg     <= '0;
            write_hold_reg   <= '0;
            bits_left_reg    <= '0;
            tick_div_reg     <= '0;
            clock_level_reg  <= 1'b0;
            pending_kind_reg <= ACT_TICK;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            out_shift_reg    <= out_shift_next;
            in_shift_reg     <= in_shift_next;
            write_hold_reg   <= write_hold_next;
            bits_left_reg    <= bits_left_next;
            tick_div_reg     <= tick_div_next;
            clock_level_reg  <= clock_level_next;
            pending_kind_reg <= pending_kind_next;
        end
    end

    always_comb
    begin
        logic [HALF_PERIOD_BITS-1:0] div_inc;
        logic [BL_W-1:0]             bl_dec;
        logic [15:0]                 rd;
        logic [IDX_W-1:0]            idx;

        phase_next        = phase_reg;
        out_shift_next    = out_shift_reg;
        in_shift_next     = in_shift_reg;
        write_hold_next   = write_hold_reg;
        bits_left_next    = bits_left_reg;
        tick_div_next     = tick_div_reg;
        clock_level_next  = clock_level_reg;
        pending_kind_next = pending_kind_reg;
        done              = 1'b0;
        div_inc           = tick_div_reg + HALF_PERIOD_BITS'(1);
        bl_dec            = (bits_left_reg != '0) ? bits_left_reg - BL_W'(1) : bits_left_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.action == ACT_READ || item.action == ACT_WRITE ||
                    item.action == ACT_WEN || item.action == ACT_WDS)
                begin
                    pending_kind_next = item.action;
                    out_shift_next    = SHIFT_BITS'(frame);
                    write_hold_next   = item.write_data[WORD_BITS-1:0];
                    bits_left_next    = BL_W'(COMMAND_BITS);
                    tick_div_next     = '0;
                    clock_level_next  = 1'b0;
                    phase_next        = PH_CMD;
                end
            end
            PH_CMD, PH_WDATA, PH_RDATA:
            begin
                if (div_inc >= hp)
                begin
                    tick_div_next = '0;
                    if (!clock_level_reg)
                    begin
                        clock_level_next = 1'b1;
                    end
                    else
                    begin
                        // falling edge: sample read bit, advance bit count
                        clock_level_next = 1'b0;
                        if (phase_reg == PH_RDATA)
                        begin
                            in_shift_next = {in_shift_reg[WORD_BITS-2:0], item.serial_in};
                        end
                        bits_left_next = bl_dec;
                        if (bl_dec == '0)
                        begin
                            if (phase_reg == PH_CMD && pending_kind_reg == ACT_READ)
                            begin
                                phase_next     = PH_RDATA;
                                bits_left_next = BL_W'(WORD_BITS);
                                in_shift_next  = '0;
                            end
                            else if (phase_reg == PH_CMD && pending_kind_reg == ACT_WRITE)
                            begin
                                phase_next     = PH_WDATA;
                                bits_left_next = BL_W'(WORD_BITS);
                                out_shift_next = SHIFT_BITS'(write_hold_reg);
                            end
                            else if (phase_reg == PH_WDATA)
                            begin
                                phase_next = PH_GAP;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    tick_div_next = div_inc;
                end
            end
            PH_GAP:
            begin
                if (div_inc >= hp)
                begin
                    tick_div_next = '0;
                    phase_next    = PH_POLL;
                end
                else
                begin
                    tick_div_next = div_inc;
                end
            end
            PH_POLL:
            begin
                // wait for the device ready level, no timeout
                if (item.serial_in)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // hold the clock low whenever no bit is on the wire
        if (phase_next == PH_IDLE || phase_next == PH_GAP || phase_next == PH_POLL)
        begin
            clock_level_next = 1'b0;
        end

        idx = bits_left_next[IDX_W-1:0] - IDX_W'(1);
        rd  = '0;
        rd[WORD_BITS-1:0] = in_shift_next;

        result.chip_select  = (phase_next == PH_CMD || phase_next == PH_WDATA ||
                               phase_next == PH_RDATA || phase_next == PH_POLL);
        result.serial_clock = clock_level_next;
        result.serial_out   = (phase_next == PH_CMD || phase_next == PH_WDATA) &&
                              (bits_left_next != '0) && out_shift_next[idx];
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.read_data    = rd;
    end

`ifndef SYNTH
    a_idle_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_GAP || phase_reg == PH_POLL)
        |-> !clock_level_reg)
        else $error("serial clock high outside a bit phase");

    a_bits_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= BL_W'(SHIFT_BITS))
        else $error("bit count beyond frame length");

    a_done_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("done pulse without return to idle");
`endif

endmodule

>>> sv/microwire_eeprom_master.sv
// ============================================================================
// microwire_eeprom_master: three-wire serial EEPROM master, 16-bit words
// Each input transaction is one tick of the serial engine; each tick gives
// one result transaction with the line levels, status and read data.
// ============================================================================
//
//  channel   handshake            payload     direction
//  --------  -------------------  ----------  ---------
//  in        in_valid / in_stall  mwe_in_t    into block
//  out       out_valid/out_stall  mwe_out_t   out of block
//  cfg       cfg_valid/cfg_ready  cfg_data    into block (half_period)
//
//  One tick per clock cycle while in_stall is low: the engine state advances
//  when a transaction is taken and the result register loads the levels of
//  that tick, so the result transaction is offered in the cycle after.
//  in_stall rises only while a result waits in the output register and
//  out_stall is high; cfg_ready is always high.
//  Reset (rst_n low) returns the engine to idle and half_period to 1.
//
module microwire_eeprom_master
    import mwe_pkg::*;
#(
    parameter int COMMAND_BITS = 11,
    parameter int ADDRESS_BITS = 8,
    parameter int WORD_BITS    = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mwe_in_t                     in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mwe_out_t                    out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [HALF_PERIOD_BITS-1:0] cfg_data
);

    logic [HALF_PERIOD_BITS-1:0] half_period_reg;
    logic                        out_valid_reg, out_valid_next;
    mwe_out_t                    out_item_reg;
    mwe_out_t                    result;
    logic                        step;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign step      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    mwe_core #(
        .COMMAND_BITS (COMMAND_BITS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .WORD_BITS    (WORD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item),
        .half_period (half_period_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_period_reg <= cfg_data;
        end
    end

    // hold the result until taken, refill in the same cycle it drains
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= result;
        end
    end

`ifndef SYNTH
    a_clock_needs_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.serial_clock |-> out_item_reg.chip_select)
        else $error("serial clock toggling with chip select low");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.done_res |-> !out_item_reg.busy_res)
        else $error("done reported while still busy");

    a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted tick produced no result");
`endif

endmodule

>>> sim/mwe_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mwe_checker: line-level predictor and comparator for the EEPROM master
// Watches the input, output and config channels. Every input transaction
// runs one tick of a private copy of the serial engine; the predicted line
// levels wait in order until the matching output transaction arrives.
// ============================================================================
module mwe_checker
    import mwe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  mwe_in_t     in_item,
    input  logic        out_valid,
    input  logic        out_stall,
    input  mwe_out_t    out_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          ticks_seen,
    output int          reads_done,
    output int          writes_done,
    output int          ctrl_done,
    output logic        engine_busy
);

    localparam int         FRAME_BITS   = 11;
    localparam logic [4:0] FRAME_COUNT  = 5'd11;
    localparam logic [4:0] WORD_COUNT   = 5'd16;
    localparam int         REPORT_LIMIT = 40;

    mwe_phase_t  phase;
    logic [15:0] out_shift;
    logic [15:0] in_shift;
    logic [15:0] write_hold;
    logic [4:0]  bits_left;
    logic [7:0]  tick_div;
    logic [7:0]  half_period;
    logic        clock_level;
    logic [2:0]  op_kind;
    mwe_out_t    levels_due[$];
    int          result_index;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch at result %0d: %s got %h want %h",
                     result_index, what, got, want);
    endtask

    // one tick of the serial engine; returns the line levels after the tick
    task automatic advance_engine(input mwe_in_t it, output mwe_out_t lv);
        logic [7:0]  hp;
        logic [15:0] frame;
        logic        done;
        hp = (half_period == 8'd0) ? 8'd1 : half_period;
        done = 1'b0;
        lv = '0;
        case (phase)
            PH_IDLE:
            begin
                if (it.action >= ACT_READ && it.action <= ACT_WDS)
                begin
                    // start bit and opcode sit in the top five command bits
                    case (it.action)
                        ACT_READ:
                            frame = ({11'd0, CMD_READ[7:3]} << (FRAME_BITS - 5))
                                    | {8'd0, it.address};
                        ACT_WRITE:
                            frame = ({11'd0, CMD_WRITE[7:3]} << (FRAME_BITS - 5))
                                    | {8'd0, it.address};
                        ACT_WEN:
                            frame = {11'd0, CMD_EWEN[7:3]} << (FRAME_BITS - 5);
                        default:
                            frame = {11'd0, CMD_EWDS[7:3]} << (FRAME_BITS - 5);
                    endcase
                    op_kind = it.action;
                    out_shift = frame;
                    write_hold = it.write_data;
                    bits_left = FRAME_COUNT;
                    tick_div = '0;
                    clock_level = 1'b0;
                    phase = PH_CMD;
                end
            end
            PH_CMD, PH_WDATA, PH_RDATA:
            begin
                tick_div = tick_div + 8'd1;
                if (tick_div >= hp)
                begin
                    tick_div = '0;
                    if (!clock_level)
                        clock_level = 1'b1;
                    else
                    begin
                        // falling edge: sample, then advance to the next bit
                        clock_level = 1'b0;
                        if (phase == PH_RDATA)
                            in_shift = {in_shift[14:0], it.serial_in};
                        if (bits_left != 5'd0)
                            bits_left = bits_left - 5'd1;
                        if (bits_left == 5'd0)
                        begin
                            if (phase == PH_CMD && op_kind == ACT_READ)
                            begin
                                phase = PH_RDATA;
                                bits_left = WORD_COUNT;
                                in_shift = '0;
                            end
                            else if (phase == PH_CMD && op_kind == ACT_WRITE)
                            begin
                                phase = PH_WDATA;
                                bits_left = WORD_COUNT;
                                out_shift = write_hold;
                            end
                            else if (phase == PH_WDATA)
                                phase = PH_GAP;
                            else
                            begin
                                phase = PH_IDLE;
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_GAP:
            begin
                tick_div = tick_div + 8'd1;
                if (tick_div >= hp)
                begin
                    tick_div = '0;
                    phase = PH_POLL;
                end
            end
            PH_POLL:
            begin
                if (it.serial_in)
                begin
                    phase = PH_IDLE;
                    done = 1'b1;
                end
            end
            default:
                phase = PH_IDLE;
        endcase

        if (done)
        begin
            if (op_kind == ACT_READ)
                reads_done++;
            else if (op_kind == ACT_WRITE)
                writes_done++;
            else
                ctrl_done++;
        end

        lv.chip_select = (phase == PH_CMD || phase == PH_WDATA ||
                          phase == PH_RDATA || phase == PH_POLL);
        if ((phase == PH_CMD || phase == PH_WDATA) &&
            bits_left >= 5'd1 && bits_left <= WORD_COUNT)
            lv.serial_out = out_shift[bits_left - 5'd1];
        if (phase == PH_IDLE || phase == PH_GAP || phase == PH_POLL)
            clock_level = 1'b0;
        lv.serial_clock = clock_level;
        lv.busy_res = (phase != PH_IDLE);
        lv.done_res = done;
        lv.read_data = in_shift;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mwe_out_t want;
        mwe_out_t got;
        if (!rst_n)
        begin
            phase = PH_IDLE;
            out_shift = '0;
            in_shift = '0;
            write_hold = '0;
            bits_left = '0;
            tick_div = '0;
            half_period = HALF_PERIOD_RESET;
            clock_level = 1'b0;
            op_kind = ACT_TICK;
            levels_due.delete();
            result_index = 0;
            fail_count = 0;
            ticks_seen = 0;
            reads_done = 0;
            writes_done = 0;
            ctrl_done = 0;
            pending <= 0;
            engine_busy <= 1'b0;
        end
        else
        begin
            // retire the oldest expectation before queuing this edge's tick
            if (out_valid && !out_stall)
            begin
                got = out_item;
                if (levels_due.size() == 0)
                    report_mismatch("result with nothing expected", got.read_data, '0);
                else
                begin
                    want = levels_due.pop_front();
                    if (got.chip_select !== want.chip_select)
                        report_mismatch("chip_select", got.chip_select, want.chip_select);
                    if (got.serial_clock !== want.serial_clock)
                        report_mismatch("serial_clock", got.serial_clock, want.serial_clock);
                    if (got.serial_out !== want.serial_out)
                        report_mismatch("serial_out", got.serial_out, want.serial_out);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                end
                result_index++;
            end
            if (in_valid && !in_stall)
            begin
                advance_engine(in_item, want);
                levels_due.push_back(want);
                ticks_seen++;
            end
            // a write on this edge takes effect from the next tick on
            if (cfg_valid && cfg_ready)
                half_period = cfg_data;
            pending <= levels_due.size();
            engine_busy <= (phase != PH_IDLE);
        end
    end

endmodule

>>> sim/tb_microwire_eeprom_master.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_microwire_eeprom_master: stimulus and verdict for the EEPROM master
// Drives tick transactions that start reads, writes and enable/disable
// commands under several half periods, with random gaps on the sender and
// random stalls on the receiver; mwe_checker predicts and compares.
// ============================================================================
module tb_microwire_eeprom_master;
    import mwe_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         SIN_RUNS        = 0;
    localparam int         SIN_ONES        = 1;
    localparam int         SIN_ZEROS       = 2;
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    mwe_in_t    in_item = '0;
    logic       in_stall;
    logic       out_valid;
    logic       cfg_ready;
    mwe_out_t   out_item;

    int   fail_count;
    int   pending;
    int   ticks_seen;
    int   reads_done;
    int   writes_done;
    int   ctrl_done;
    logic engine_busy;

    int   sin_mode = SIN_RUNS;
    int   sin_run = 0;
    logic sin_level = 1'b0;
    bit   calm = 1'b0;
    int   stall_run = 0;
    int   quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    microwire_eeprom_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mwe_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .ticks_seen  (ticks_seen),
        .reads_done  (reads_done),
        .writes_done (writes_done),
        .ctrl_done   (ctrl_done),
        .engine_busy (engine_busy)
    );

    // receiver: runs of stall and no stall, mostly short
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            if (calm || $urandom_range(0, 99) < 60)
            begin
                out_stall <= 1'b0;
                stall_run = calm ? 1 : ($urandom_range(0, 9) == 0 ?
                            $urandom_range(20, 60) : $urandom_range(1, 8));
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run = ($urandom_range(0, 9) == 0) ?
                            $urandom_range(20, 60) : $urandom_range(1, 3);
            end
        end
        stall_run--;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL microwire_eeprom_master");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // device data line: held levels of random length, or forced
    function automatic logic next_sin();
        if (sin_mode == SIN_ONES)
            return 1'b1;
        if (sin_mode == SIN_ZEROS)
            return 1'b0;
        if (sin_run == 0)
        begin
            sin_level = 1'($urandom_range(0, 1));
            sin_run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                      $urandom_range(4, 40);
        end
        sin_run--;
        return sin_level;
    endfunction

    function automatic logic [2:0] choose_action(input logic busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy)
            return (r < 85) ? ACT_TICK : 3'($urandom_range(0, 7));
        if (r < 70)
            return 3'($urandom_range(ACT_READ, ACT_WDS));
        if (r < 85)
            return ACT_TICK;
        return 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    function automatic mwe_in_t random_item();
        mwe_in_t it;
        int r;
        it = '0;
        r = $urandom_range(0, 9);
        it.address = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        it.write_data = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                        16'($urandom_range(0, 65535));
        return it;
    endfunction

    // called and returns just after a falling edge
    task automatic send_tick(input mwe_in_t it, input bit pick_action);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (pick_action)
            it.action = choose_action(engine_busy);
        it.serial_in = next_sin();
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // tick until the engine is idle and every result is back
    task automatic finish_operation();
        while (engine_busy)
            send_tick(random_item(), 1'b1);
        hold_until_drained();
    endtask

    task automatic write_half_period(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_op(input logic [2:0] action, input logic [7:0] address,
                          input logic [15:0] data, input int mode);
        mwe_in_t it;
        it = '0;
        it.action = action;
        it.address = address;
        it.write_data = data;
        sin_mode = mode;
        send_tick(it, 1'b0);
        finish_operation();
        sin_mode = SIN_RUNS;
    endtask

    // start an operation, run it part way, then let every result come back
    task automatic start_op(input logic [2:0] action, input logic [7:0] address,
                            input logic [15:0] data, input int ticks);
        mwe_in_t it;
        it = '0;
        it.action = action;
        it.address = address;
        it.write_data = data;
        send_tick(it, 1'b0);
        repeat (ticks)
            send_tick(random_item(), 1'b1);
        hold_until_drained();
    endtask

    task automatic random_phase(input int count, input logic [7:0] hp, input bit quiet);
        finish_operation();
        write_half_period(hp);
        calm = quiet;
        repeat (count)
        begin
            // now and then let every result come back before going on
            if ($urandom_range(0, 299) == 0)
                hold_until_drained();
            send_tick(random_item(), 1'b1);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, every command, spare codes, busy actions
        run_op(ACT_READ, 8'h00, 16'h0000, SIN_ONES);
        run_op(ACT_READ, 8'hFF, 16'hFFFF, SIN_ZEROS);
        run_op(ACT_WRITE, 8'h00, 16'h0000, SIN_RUNS);
        run_op(ACT_WRITE, 8'hFF, 16'hFFFF, SIN_RUNS);
        run_op(ACT_WEN, 8'hA5, 16'h5A5A, SIN_RUNS);
        run_op(ACT_WDS, 8'h5A, 16'hA5A5, SIN_RUNS);
        run_op(ACT_SPARE_FIRST, 8'h12, 16'h3456, SIN_RUNS);
        run_op(ACT_SPARE_FIRST + 3'd1, 8'h34, 16'h5678, SIN_RUNS);
        run_op(ACT_SPARE_LAST, 8'h56, 16'h789A, SIN_RUNS);
        run_op(ACT_TICK, 8'h78, 16'h9ABC, SIN_RUNS);
        run_op(ACT_WRITE, 8'h3C, 16'hC33C, SIN_RUNS);

        // longest half period: first clock rise and fall, then finish fast
        write_half_period(8'd255);
        start_op(ACT_WRITE, 8'h18, 16'h6C93, 520);
        write_half_period(8'd1);
        finish_operation();

        // zero behaves as one
        write_half_period(8'd0);
        run_op(ACT_WRITE, 8'h7E, 16'h8001, SIN_RUNS);
        run_op(ACT_READ, 8'hC3, 16'h0000, SIN_ONES);
        run_op(ACT_WEN, 8'h00, 16'h0000, SIN_RUNS);

        random_phase(150, 8'd1, 1'b0);
        random_phase(150, 8'd2, 1'b0);
        random_phase(130, 8'd3, 1'b1);
        random_phase(80, 8'($urandom_range(4, 12)), 1'b0);
        random_phase(150, 8'd1, 1'b0);
        random_phase(120, 8'd2, 1'b0);

        finish_operation();
        repeat (4) @(negedge clk);

        $display("covered %0d ticks: %0d reads, %0d writes, %0d enable/disable commands",
                 ticks_seen, reads_done, writes_done, ctrl_done);
        $display("half periods 0, 1, 2, 3, 255 and one of 4..12, with gaps and stalls");
        if (fail_count == 0 && pending == 0)
            $display("PASS microwire_eeprom_master");
        else
            $display("FAIL microwire_eeprom_master");
        $finish;
    end

endmodule

>>> microwire_eeprom_master.f
sv/mwe_pkg.sv
sv/mwe_core.sv
sv/microwire_eeprom_master.sv
sim/mwe_checker.sv
sim/tb_microwire_eeprom_master.sv
